// ===== rtl/core/gaoi_pkg.sv =====
// Shared types and constants for the grid area-of-interest table.
// Used by the controller, the datapath and the top level.
package gaoi_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;
   localparam logic [1:0] OP_QUERY  = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   localparam int         RES_W       = 6;
   localparam logic [5:0] MAX_RESULTS = 6'd63;

   localparam logic [30:0] CELL_SIZE_RESET = 31'd6553600;

   typedef enum logic [2:0] {
      IDLE, FIND, WAIT_DIV, EXEC, ORIGIN, SCAN, FLUSH, RESP
   } state_type;

   typedef struct packed {
      logic       load;
      logic       scan_init;
      logic       query_mode;
      logic       scan_run;
      logic       write_slot;
      logic       clear_slot;
      logic       origin_rd;
      logic       origin_cap;
      logic       set_status;
      logic [1:0] status;
      logic       flush;
      logic       resp;
   } cmd_type;

   typedef struct packed {
      logic       scan_end;
      logic       div_done;
      logic       found;
      logic       has_free;
      logic       out_free;
      logic [1:0] op;
   } sts_type;

endpackage

// ===== rtl/core/gaoi_if.sv =====
// Item channels of the grid area-of-interest table: request and response.
// Stand-alone interfaces, no dependencies.
interface gaoi_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [63:0]        object_id;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;

   modport source (output valid, opcode, object_id, pos_x, pos_y, input ready);
   modport sink   (input valid, opcode, object_id, pos_x, pos_y, output ready);
endinterface

interface gaoi_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        id_valid;
   logic [63:0] visible_id;
   logic        last;

   modport source (output valid, status, id_valid, visible_id, last, input ready);
   modport sink   (input valid, status, id_valid, visible_id, last, output ready);
endinterface

// ===== rtl/core/grid_area_of_interest_table.sv =====
// Grid area-of-interest table: up to MAX_OBJECTS objects, each kept in the grid cell
// floor(pos / cell_size) of its Q16.16 position. Opcodes add, remove, update and query
// (all other objects in the 3x3 cells around the asked one, dx outer, dy inner, then slot
// order, at most 63 results, the final one marked last). One item is worked on at a time.
// Every item first scans the slot RAM once while two dividers compute the cell. A query
// whose object is found then scans the RAM nine more times, one slot per cycle unless
// the response side stalls. The table is empty after reset; no clearing pass is needed.
module grid_area_of_interest_table
   import gaoi_pkg::*;
#(
   parameter int MAX_OBJECTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   gaoi_req_if.sink    req,
   gaoi_rsp_if.source  rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [30:0] cell_size_ff, cell_size_in;
   logic        csr_wr;
   cmd_type     cmd;
   sts_type     sts;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      cell_size_in = cell_size_ff;
      if (csr_wr && !paddr[2]) begin
         cell_size_in = pwdata[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= CELL_SIZE_RESET;
      end else begin
         cell_size_ff <= cell_size_in;
      end
   end

   assign prdata = paddr[2] ? 32'd0 : {1'b0, cell_size_ff};

   gaoi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gaoi_dp #(
      .MAX_OBJECTS (MAX_OBJECTS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .opcode         (req.opcode),
      .object_id      (req.object_id),
      .pos_x          (req.pos_x),
      .pos_y          (req.pos_y),
      .cell_size      (cell_size_ff),
      .rsp_ready      (rsp.ready),
      .rsp_valid      (rsp.valid),
      .rsp_status     (rsp.status),
      .rsp_id_valid   (rsp.id_valid),
      .rsp_visible_id (rsp.visible_id),
      .rsp_last       (rsp.last)
   );

   a_no_id_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.id_valid |-> rsp.last && rsp.visible_id == 64'd0)
      else $error("response without neighbor id is not a final item");

   a_error_no_id: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != STATUS_OK |-> !rsp.id_valid)
      else $error("error status carries a neighbor id");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("new item taken while one is in work");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr && !paddr[2] |=> cell_size_ff == $past(pwdata[30:0]))
      else $error("cell size write lost");

endmodule

// ===== rtl/core/gaoi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gaoi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/gaoi_div.sv =====
// Iterative floor divider: signed 32-bit dividend by unsigned 31-bit divisor,
// one quotient bit per cycle. No dependencies.
module gaoi_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] dividend,
   input  logic [30:0]        divisor,
   output logic               done,
   output logic [31:0]        quotient
);

   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] mag_ff, mag_in;
   logic [31:0] rem_ff, rem_in;
   logic [30:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [31:0] rem_sh;
   logic        ge;

   always_comb begin
      rem_sh  = {rem_ff[30:0], mag_ff[31]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         neg_in  = dividend[31];
         mag_in  = dividend[31] ? (~dividend + 32'd1) : dividend;
         dvs_in  = (divisor == 31'd0) ? 31'd1 : divisor;
         rem_in  = 32'd0;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         mag_in = {mag_ff[30:0], ge};
         rem_in = ge ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   // negative with remainder rounds toward minus infinity: -(q) - 1 = ~q
   always_comb begin
      if (!neg_ff) begin
         quotient = mag_ff;
      end else if (rem_ff != 32'd0) begin
         quotient = ~mag_ff;
      end else begin
         quotient = ~mag_ff + 32'd1;
      end
   end

   assign done = !busy_ff;

endmodule

// ===== rtl/core/gaoi_ctrl.sv =====
// Controller state machine of the grid area-of-interest table.
// Depends on gaoi_pkg; drives the datapath through cmd_type, reads sts_type.
module gaoi_ctrl
   import gaoi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               state_in = FIND;
            end
         end
         FIND: begin
            if (sts.scan_end) begin
               state_in = WAIT_DIV;
            end
         end
         WAIT_DIV: begin
            if (sts.div_done) begin
               state_in = EXEC;
            end
         end
         EXEC: begin
            if (sts.op == OP_QUERY && sts.found) begin
               state_in = ORIGIN;
            end else begin
               state_in = RESP;
            end
         end
         ORIGIN: state_in = SCAN;
         SCAN: begin
            if (sts.scan_end) begin
               state_in = FLUSH;
            end
         end
         FLUSH: begin
            if (sts.out_free) begin
               state_in = IDLE;
            end
         end
         RESP: begin
            if (sts.out_free) begin
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         IDLE: begin
            req_ready     = 1'b1;
            cmd.load      = req_valid;
            cmd.scan_init = req_valid;
         end
         FIND: cmd.scan_run = 1'b1;
         WAIT_DIV: ;
         EXEC: begin
            case (sts.op)
               OP_ADD, OP_UPDATE: begin
                  cmd.set_status = 1'b1;
                  cmd.write_slot = sts.found || sts.has_free;
                  cmd.status     = (sts.found || sts.has_free) ? STATUS_OK : STATUS_FULL;
               end
               OP_REMOVE: begin
                  cmd.set_status = 1'b1;
                  cmd.clear_slot = sts.found;
                  cmd.status     = sts.found ? STATUS_OK : STATUS_NOT_FOUND;
               end
               OP_QUERY: begin
                  cmd.origin_rd  = sts.found;
                  cmd.set_status = !sts.found;
                  cmd.status     = STATUS_NOT_FOUND;
               end
               default: ;
            endcase
         end
         ORIGIN: begin
            cmd.origin_cap = 1'b1;
            cmd.scan_init  = 1'b1;
            cmd.query_mode = 1'b1;
         end
         SCAN:  cmd.scan_run = 1'b1;
         FLUSH: cmd.flush    = sts.out_free;
         RESP:  cmd.resp     = sts.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/gaoi_dp.sv =====
// Datapath of the grid area-of-interest table: slot RAM, occupancy bits,
// cell dividers, slot scan pipeline and response register. Depends on gaoi_pkg.
module gaoi_dp
   import gaoi_pkg::*;
#(
   parameter int MAX_OBJECTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [1:0]         opcode,
   input  logic [63:0]        object_id,
   input  logic signed [31:0] pos_x,
   input  logic signed [31:0] pos_y,
   input  logic [30:0]        cell_size,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic               rsp_id_valid,
   output logic [63:0]        rsp_visible_id,
   output logic               rsp_last
);

   localparam int            IW       = $clog2(MAX_OBJECTS);
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_OBJECTS - 1);

   logic [1:0]             op_ff, op_in;
   logic [63:0]            id_ff, id_in;
   logic                   qmode_ff, qmode_in;
   logic [IW-1:0]          addr_ff, addr_in;
   logic [1:0]             dx_ff, dx_in, dy_ff, dy_in;
   logic                   issued_ff, issued_in;
   logic                   s2_valid_ff, s2_valid_in;
   logic [IW-1:0]          s2_idx_ff, s2_idx_in;
   logic [1:0]             s2_dx_ff, s2_dx_in, s2_dy_ff, s2_dy_in;
   logic                   s2_final_ff, s2_final_in;
   logic                   found_ff, found_in;
   logic [IW-1:0]          slot_ff, slot_in;
   logic                   has_free_ff, has_free_in;
   logic [IW-1:0]          free_ff, free_in;
   logic [MAX_OBJECTS-1:0] used_ff, used_in;
   logic [31:0]            ox_ff, ox_in, oy_ff, oy_in;
   logic [RES_W-1:0]       n_ff, n_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [63:0]            pend_id_ff, pend_id_in;
   logic [1:0]             st_ff, st_in;
   logic                   out_valid_ff, out_valid_in;
   logic [1:0]             out_st_ff, out_st_in;
   logic                   out_idv_ff, out_idv_in;
   logic [63:0]            out_id_ff, out_id_in;
   logic                   out_last_ff, out_last_in;

   logic          div_x_done, div_y_done;
   logic [31:0]   cell_x, cell_y;
   logic [127:0]  ram_rd, ram_wd;
   logic          ram_re;
   logic [IW-1:0] ram_ra, ram_wa;
   logic [63:0]   rd_obj;
   logic [31:0]   rd_cx, rd_cy;
   logic [1:0]    dxo, dyo;
   logic [32:0]   tgt_x, tgt_y;
   logic          cell_hit, hit, out_free, stall, adv, issue, final_issue, scan_end;

   gaoi_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.load),
      .dividend (pos_x),
      .divisor  (cell_size),
      .done     (div_x_done),
      .quotient (cell_x)
   );

   gaoi_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.load),
      .dividend (pos_y),
      .divisor  (cell_size),
      .done     (div_y_done),
      .quotient (cell_y)
   );

   // entry layout: object id, cell x, cell y
   gaoi_ram #(
      .WIDTH (128),
      .DEPTH (MAX_OBJECTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.write_slot),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   always_comb begin
      rd_obj   = ram_rd[127:64];
      rd_cx    = ram_rd[63:32];
      rd_cy    = ram_rd[31:0];
      dxo      = s2_dx_ff - 2'd1;
      dyo      = s2_dy_ff - 2'd1;
      // 33-bit targets so that the cells next to the grid edge do not wrap
      tgt_x    = {ox_ff[31], ox_ff} + {{31{dxo[1]}}, dxo};
      tgt_y    = {oy_ff[31], oy_ff} + {{31{dyo[1]}}, dyo};
      cell_hit = ({rd_cx[31], rd_cx} == tgt_x) && ({rd_cy[31], rd_cy} == tgt_y);
      hit      = cmd.scan_run && s2_valid_ff && qmode_ff && used_ff[s2_idx_ff]
                 && (s2_idx_ff != slot_ff) && cell_hit && (n_ff != MAX_RESULTS);
      out_free = !out_valid_ff || rsp_ready;
      stall    = hit && pend_valid_ff && !out_free;
      adv      = cmd.scan_run && !stall;
      issue    = adv && !issued_ff;
      final_issue = (addr_ff == LAST_IDX) && (!qmode_ff || (dx_ff == 2'd2 && dy_ff == 2'd2));
      scan_end = adv && s2_valid_ff
                 && (s2_final_ff || (hit && n_ff == MAX_RESULTS - 6'd1));
      ram_re   = issue || cmd.origin_rd;
      ram_ra   = cmd.origin_rd ? slot_ff : addr_ff;
      ram_wa   = found_ff ? slot_ff : free_ff;
      ram_wd   = {id_ff, cell_x, cell_y};
   end

   always_comb begin
      op_in         = op_ff;
      id_in         = id_ff;
      qmode_in      = qmode_ff;
      addr_in       = addr_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      issued_in     = issued_ff;
      s2_valid_in   = s2_valid_ff;
      s2_idx_in     = s2_idx_ff;
      s2_dx_in      = s2_dx_ff;
      s2_dy_in      = s2_dy_ff;
      s2_final_in   = s2_final_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      has_free_in   = has_free_ff;
      free_in       = free_ff;
      used_in       = used_ff;
      ox_in         = ox_ff;
      oy_in         = oy_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      st_in         = st_ff;
      out_valid_in  = out_valid_ff;
      out_st_in     = out_st_ff;
      out_idv_in    = out_idv_ff;
      out_id_in     = out_id_ff;
      out_last_in   = out_last_ff;

      if (cmd.load) begin
         op_in = opcode;
         id_in = object_id;
      end

      if (cmd.scan_init) begin
         qmode_in    = cmd.query_mode;
         addr_in     = '0;
         dx_in       = 2'd0;
         dy_in       = 2'd0;
         issued_in   = 1'b0;
         s2_valid_in = 1'b0;
         n_in          = '0;
         pend_valid_in = 1'b0;
         if (!cmd.query_mode) begin
            found_in    = 1'b0;
            has_free_in = 1'b0;
         end
      end else if (adv) begin
         s2_valid_in = issue;
         s2_idx_in   = addr_ff;
         s2_dx_in    = dx_ff;
         s2_dy_in    = dy_ff;
         s2_final_in = final_issue;
         if (issue) begin
            issued_in = final_issue;
            if (addr_ff == LAST_IDX) begin
               addr_in = '0;
               if (dy_ff == 2'd2) begin
                  dy_in = 2'd0;
                  dx_in = dx_ff + 2'd1;
               end else begin
                  dy_in = dy_ff + 2'd1;
               end
            end else begin
               addr_in = addr_ff + IW'(1);
            end
         end
      end

      // id lookup and lowest free slot
      if (cmd.scan_run && s2_valid_ff && !qmode_ff) begin
         if (used_ff[s2_idx_ff] && rd_obj == id_ff && !found_ff) begin
            found_in = 1'b1;
            slot_in  = s2_idx_ff;
         end
         if (!used_ff[s2_idx_ff] && !has_free_ff) begin
            has_free_in = 1'b1;
            free_in     = s2_idx_ff;
         end
      end

      if (cmd.write_slot) begin
         used_in[ram_wa] = 1'b1;
      end
      if (cmd.clear_slot) begin
         used_in[slot_ff] = 1'b0;
      end
      if (cmd.set_status) begin
         st_in = cmd.status;
      end
      if (cmd.origin_cap) begin
         ox_in = rd_cx;
         oy_in = rd_cy;
      end

      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      // one match is held back so the final one can carry last
      if (hit && adv) begin
         n_in          = n_ff + RES_W'(1);
         pend_valid_in = 1'b1;
         pend_id_in    = rd_obj;
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_st_in    = STATUS_OK;
            out_idv_in   = 1'b1;
            out_id_in    = pend_id_ff;
            out_last_in  = 1'b0;
         end
      end else if (cmd.flush) begin
         out_valid_in = 1'b1;
         out_st_in    = STATUS_OK;
         out_idv_in   = pend_valid_ff;
         out_id_in    = pend_valid_ff ? pend_id_ff : 64'd0;
         out_last_in  = 1'b1;
      end else if (cmd.resp) begin
         out_valid_in = 1'b1;
         out_st_in    = st_ff;
         out_idv_in   = 1'b0;
         out_id_in    = 64'd0;
         out_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issued_ff     <= 1'b0;
         s2_valid_ff   <= 1'b0;
         found_ff      <= 1'b0;
         has_free_ff   <= 1'b0;
         used_ff       <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         qmode_ff      <= 1'b0;
      end else begin
         issued_ff     <= issued_in;
         s2_valid_ff   <= s2_valid_in;
         found_ff      <= found_in;
         has_free_ff   <= has_free_in;
         used_ff       <= used_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         qmode_ff      <= qmode_in;
      end
      op_ff       <= op_in;
      id_ff       <= id_in;
      addr_ff     <= addr_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      s2_idx_ff   <= s2_idx_in;
      s2_dx_ff    <= s2_dx_in;
      s2_dy_ff    <= s2_dy_in;
      s2_final_ff <= s2_final_in;
      slot_ff     <= slot_in;
      free_ff     <= free_in;
      ox_ff       <= ox_in;
      oy_ff       <= oy_in;
      pend_id_ff  <= pend_id_in;
      st_ff       <= st_in;
      out_st_ff   <= out_st_in;
      out_idv_ff  <= out_idv_in;
      out_id_ff   <= out_id_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      sts.scan_end = scan_end;
      sts.div_done = div_x_done && div_y_done;
      sts.found    = found_ff;
      sts.has_free = has_free_ff;
      sts.out_free = out_free;
      sts.op       = op_ff;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_st_ff;
   assign rsp_id_valid   = out_idv_ff;
   assign rsp_visible_id = out_id_ff;
   assign rsp_last       = out_last_ff;

endmodule

// ===== test/tb.sv =====
// Testbench for grid_area_of_interest_table: directed and random add, remove, update and
// query items, each checked against an in-bench model of the slot table and grid cells.
// Depends on gaoi_pkg and the gaoi_req_if / gaoi_rsp_if interfaces.
module tb
   import gaoi_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ADDR_CELL_SIZE = 3'd0;
   localparam int SLOTS = 64;
   localparam int CYCLE_LIMIT = 2_500_000;
   localparam int POOL_N = 72;

   typedef struct {
      logic [1:0]  status;
      logic        id_valid;
      logic [63:0] visible_id;
      logic        last;
   } neighbor_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   gaoi_req_if req ();
   gaoi_rsp_if rsp ();

   grid_area_of_interest_table DUT (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // model of the table
   logic [30:0] cell_size;
   logic        used_tab [SLOTS];
   logic [63:0] obj_tab [SLOTS];
   int          cx_tab [SLOTS];
   int          cy_tab [SLOTS];

   neighbor_rsp_type expected_q [$];
   logic [63:0]      id_pool [POOL_N];
   int               mismatches = 0;
   int               cycles = 0;
   int               burst_left = 0;
   int               hold_req = 0;
   int               hold_left = 0;
   int               stall_ctr = 0;

   initial begin
      req.valid = 1'b0;
      req.opcode = OP_ADD;
      req.object_id = '0;
      req.pos_x = '0;
      req.pos_y = '0;
      rsp.ready = 1'b0;
   end

   function automatic int cell_of(logic signed [31:0] p);
      longint pl, d, q;
      pl = p;
      d = (cell_size == 0) ? 1 : longint'(cell_size);
      q = pl / d;
      if ((pl % d) != 0 && pl < 0) q = q - 1;
      return int'(q);
   endfunction

   function automatic void push_rsp(logic [1:0] st, logic iv, logic [63:0] id, logic lst);
      neighbor_rsp_type r;
      r.status = st;
      r.id_valid = iv;
      r.visible_id = id;
      r.last = lst;
      expected_q = {expected_q, r};
   endfunction

   function automatic void predict_table_op(logic [1:0] op, logic [63:0] id,
                                            logic signed [31:0] x, logic signed [31:0] y);
      int s, n, cx, cy;
      longint tx, ty;
      s = -1;
      n = 0;
      cx = cell_of(x);
      cy = cell_of(y);
      for (int i = 0; i < SLOTS; i++)
         if (s < 0 && used_tab[i] && obj_tab[i] == id) s = i;
      if (op == OP_ADD || op == OP_UPDATE) begin
         if (s < 0) begin
            for (int i = 0; i < SLOTS; i++)
               if (s < 0 && !used_tab[i]) s = i;
            if (s < 0) begin
               push_rsp(STATUS_FULL, 1'b0, '0, 1'b1);
               return;
            end
            used_tab[s] = 1'b1;
            obj_tab[s] = id;
         end
         cx_tab[s] = cx;
         cy_tab[s] = cy;
         push_rsp(STATUS_OK, 1'b0, '0, 1'b1);
      end else if (op == OP_REMOVE) begin
         if (s < 0) push_rsp(STATUS_NOT_FOUND, 1'b0, '0, 1'b1);
         else begin
            used_tab[s] = 1'b0;
            push_rsp(STATUS_OK, 1'b0, '0, 1'b1);
         end
      end else if (s < 0) begin
         push_rsp(STATUS_NOT_FOUND, 1'b0, '0, 1'b1);
      end else begin
         for (int dx = -1; dx <= 1; dx++)
            for (int dy = -1; dy <= 1; dy++) begin
               // cells past the 32-bit range must not wrap
               tx = longint'(cx_tab[s]) + dx;
               ty = longint'(cy_tab[s]) + dy;
               for (int i = 0; i < SLOTS; i++)
                  if (n < int'(MAX_RESULTS) && i != s && used_tab[i] &&
                      longint'(cx_tab[i]) == tx && longint'(cy_tab[i]) == ty) begin
                     push_rsp(STATUS_OK, 1'b1, obj_tab[i], 1'b0);
                     n++;
                  end
            end
         if (n == 0) push_rsp(STATUS_OK, 1'b0, '0, 1'b1);
         else expected_q[expected_q.size() - 1].last = 1'b1;
      end
   endfunction

   // result checker and input monitor
   always @(posedge clock) begin
      neighbor_rsp_type e;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: status=%0d id_valid=%0d id=%h last=%0d",
                           rsp.status, rsp.id_valid, rsp.visible_id, rsp.last);
            end else begin
               e = expected_q.pop_front();
               if (e.status !== rsp.status || e.id_valid !== rsp.id_valid ||
                   e.visible_id !== rsp.visible_id || e.last !== rsp.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: exp status=%0d id_valid=%0d id=%h last=%0d,",
                              e.status, e.id_valid, e.visible_id, e.last);
                     $display("          got status=%0d id_valid=%0d id=%h last=%0d",
                              rsp.status, rsp.id_valid, rsp.visible_id, rsp.last);
                  end
               end
            end
         end
         if (req.valid && req.ready)
            predict_table_op(req.opcode, req.object_id, req.pos_x, req.pos_y);
      end
   end

   // receiver: free-running stall pattern plus requested long hold-offs
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else begin
         if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
         end
         if (hold_left > 0) begin
            rsp.ready <= 1'b0;
            hold_left--;
         end else begin
            stall_ctr++;
            rsp.ready <= (stall_ctr % 600 < 300) ? 1'b1 : ($urandom_range(0, 2) != 0);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_item(logic [1:0] op, logic [63:0] id,
                            logic signed [31:0] x, logic signed [31:0] y);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      burst_left--;
      req.valid <= 1'b1;
      req.opcode <= op;
      req.object_id <= id;
      req.pos_x <= x;
      req.pos_y <= y;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_cell_size(logic [30:0] v);
      drain();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_CELL_SIZE;
      pwdata <= {1'b0, v};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      cell_size = v;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_pos();
      longint cs, v;
      cs = (cell_size == 0) ? 1 : longint'(cell_size);
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: begin
            v = (longint'($urandom_range(0, 5999)) * cs) / 1000 - 3 * cs
                + $urandom_range(0, 3);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v[31:0];
         end
      endcase
   endfunction

   task automatic random_items(int count);
      logic [1:0] op;
      int r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         op = (r < 30) ? OP_ADD : (r < 42) ? OP_REMOVE : (r < 62) ? OP_UPDATE : OP_QUERY;
         send_item(op, id_pool[$urandom_range(0, POOL_N - 1)], rand_pos(), rand_pos());
      end
   endtask

   task automatic test_basic_ops();
      send_item(OP_QUERY, id_pool[0], 0, 0);                      // unknown id
      send_item(OP_REMOVE, id_pool[1], 0, 0);                     // unknown id
      send_item(OP_ADD, id_pool[0], 0, 0);
      send_item(OP_QUERY, id_pool[0], 0, 0);                      // no neighbors
      send_item(OP_UPDATE, id_pool[1], 32'sh00640000, 32'sh00640000); // unknown -> add
      send_item(OP_ADD, id_pool[2], 32'sh7fffffff, 32'sh7fffffff);
      send_item(OP_ADD, id_pool[2], -32'sh00010000, 32'sh00010000);   // re-add moves it
      send_item(OP_QUERY, id_pool[0], 0, 0);
      send_item(OP_UPDATE, id_pool[1], 32'sh80000000, 32'sh80000000);
      send_item(OP_QUERY, id_pool[2], 0, 0);
      send_item(OP_REMOVE, id_pool[2], 0, 0);
      send_item(OP_QUERY, id_pool[0], 0, 0);
      send_item(OP_REMOVE, id_pool[0], 0, 0);
      send_item(OP_REMOVE, id_pool[1], 0, 0);
   endtask

   task automatic test_grid_edges();
      write_cell_size(31'd1);
      send_item(OP_ADD, id_pool[3], 32'sh80000000, 32'sh80000000);
      send_item(OP_ADD, id_pool[4], 32'sh7fffffff, 32'sh7fffffff);
      send_item(OP_ADD, id_pool[5], 32'sh80000001, 32'sh7ffffffe);
      send_item(OP_ADD, id_pool[6], 32'sh7ffffffe, 32'sh80000001);
      send_item(OP_QUERY, id_pool[3], 0, 0);
      send_item(OP_QUERY, id_pool[4], 0, 0);
      write_cell_size(31'd0);                                     // treated as one
      send_item(OP_UPDATE, id_pool[5], -32'sd1, 32'sd1);
      send_item(OP_UPDATE, id_pool[6], 32'sd0, 32'sd2);
      send_item(OP_QUERY, id_pool[5], 0, 0);
      for (int i = 3; i <= 6; i++) send_item(OP_REMOVE, id_pool[i], 0, 0);
   endtask

   task automatic test_full_table();
      write_cell_size(31'h7fffffff);
      for (int i = 0; i < SLOTS; i++)
         send_item(OP_ADD, id_pool[i], $urandom, $urandom);
      send_item(OP_QUERY, id_pool[10], 0, 0);                     // result cap
      send_item(OP_ADD, id_pool[SLOTS], 0, 0);                    // full
      send_item(OP_UPDATE, id_pool[SLOTS + 1], 0, 0);             // full
      for (int i = 0; i < SLOTS; i += 2) send_item(OP_REMOVE, id_pool[i], 0, 0);
   endtask

   task automatic test_random_mix();
      write_cell_size(CELL_SIZE_RESET);
      random_items(70);
      write_cell_size(31'd3000);
      hold_req = 3000;                    // block backs up, input stalls
      random_items(70);
      write_cell_size(31'd1);
      random_items(35);
      drain();                            // sender pauses until all results are in
      random_items(35);
      write_cell_size(31'h7fffffff);
      random_items(50);
      write_cell_size(31'($urandom_range(1, 32'h00ffffff)));
      random_items(74);
   endtask

   initial begin
      cell_size = CELL_SIZE_RESET;
      for (int i = 0; i < SLOTS; i++) used_tab[i] = 1'b0;
      for (int i = 0; i < POOL_N; i++) id_pool[i] = {$urandom, $urandom};
      id_pool[0] = '0;
      id_pool[1] = '1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_ops();
      test_grid_edges();
      test_full_table();
      test_random_mix();
      drain();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/core/gaoi_pkg.sv
rtl/core/gaoi_if.sv
rtl/core/gaoi_ram.sv
rtl/core/gaoi_div.sv
rtl/core/gaoi_ctrl.sv
rtl/core/gaoi_dp.sv
rtl/core/grid_area_of_interest_table.sv
test/tb.sv
